// ===== src/iws_pkg.sv =====
package iws_pkg;

  // Default number of frames that may wait for transmission.
  localparam int DEFAULT_QUEUE_DEPTH = 255;

  // Most frames that one kick sends.
  localparam int MAX_FRAMES = 63;

  // Depth of the command queue between front and back.
  localparam int QUEUE_ENTRIES = 4;
  localparam int QPTR_W = $clog2(QUEUE_ENTRIES);

  // Input command codes.
  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_KICK    = 2'd1;
  localparam logic [1:0] CMD_ACK     = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_ENQ   = 2'd2;

  // Timer actions.
  localparam logic [1:0] TMR_NONE       = 2'd0;
  localparam logic [1:0] TMR_START_T1   = 2'd1;
  localparam logic [1:0] TMR_START_T3   = 2'd2;
  localparam logic [1:0] TMR_RESTART_T1 = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EXTENDED = 2'd0;
  localparam logic [1:0] CFG_WINDOW   = 2'd1;
  localparam logic [1:0] CFG_DAMA     = 2'd2;

  // Operations that the front hands to the back.
  typedef enum logic [1:0] {
    OP_ENQ,
    OP_KICK,
    OP_ACK
  } op_t;

  // One queued operation with its sequence numbers already reduced.
  typedef struct packed {
    op_t        op;
    logic [6:0] nr;
    logic [6:0] vr;
  } q_entry_t;

  // Configuration as seen by the back.
  typedef struct packed {
    logic       extended;
    logic [5:0] window;
    logic       dama;
  } cfg_t;

  // Back sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

endpackage

// ===== src/iws_front.sv =====
module iws_front
  import iws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        extended,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata fields, low bit up: ack_number[6:0], receive_seq[6:0],
  // link_connected, peer_busy.
  input  logic [15:0] s_tdata,
  // s_tuser fields, low bit up: command[1:0].
  input  logic [1:0]  s_tuser,
  input  logic        q_full,
  output logic        q_push,
  output q_entry_t    q_entry
);

  logic [6:0] mask;
  logic       keep;
  logic       connected;
  logic       busy;

  assign mask      = extended ? 7'h7f : 7'h07;
  assign connected = s_tdata[14];
  assign busy      = s_tdata[15];

  // Every transaction is taken while the queue has room; some are dropped.
  assign s_tready = !q_full;

  // Decode the command and drop those that can never produce results.
  always_comb begin
    keep       = 1'b0;
    q_entry.op = OP_ENQ;
    q_entry.nr = s_tdata[6:0] & mask;
    q_entry.vr = s_tdata[13:7] & mask;
    unique case (s_tuser)
      CMD_ENQUEUE: begin
        keep       = 1'b1;
        q_entry.op = OP_ENQ;
      end
      CMD_KICK: begin
        keep       = connected && !busy;
        q_entry.op = OP_KICK;
      end
      CMD_ACK: begin
        keep       = 1'b1;
        q_entry.op = OP_ACK;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = s_tvalid && s_tready && keep;

  // A push never lands on a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("front pushed into a full queue");

endmodule

// ===== src/iws_fifo.sv =====
module iws_fifo
  import iws_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wr_entry,
  output logic     full,
  input  logic     pop,
  output logic     rd_valid,
  output q_entry_t rd_entry
);

  q_entry_t          entries [QUEUE_ENTRIES];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_ENTRIES));
  assign rd_valid = (count != '0);
  assign rd_entry = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_entry;
  end

  // The back only takes an entry that is present.
  assert property (@(posedge clk) disable iff (rst) pop |-> rd_valid)
    else $error("queue popped while empty");

endmodule

// ===== src/iws_back.sv =====
module iws_back
  import iws_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  q_entry_t    q_entry,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  localparam int WCW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [15:0] make_cw(input logic ext, input logic [6:0] ns,
                                          input logic [6:0] nr, input logic p);
    if (ext) return {nr, p, ns, 1'b0};
    return {8'h00, nr[2:0], p, ns[2:0], 1'b0};
  endfunction

  back_state_t state, state_next;
  logic [6:0]  send_state, send_state_next;
  logic [6:0]  ack_state, ack_state_next;
  logic [WCW-1:0] waiting, waiting_next;
  logic [6:0]  unacked, unacked_next;
  logic        t1_running, t1_running_next;
  logic [6:0]  cur, cur_next;
  logic [6:0]  end_seq, end_seq_next;
  logic [6:0]  vr_hold, vr_hold_next;
  logic [5:0]  frame_cnt, frame_cnt_next;
  logic        out_valid, out_valid_next;

  logic [1:0]  out_kind, out_kind_next;
  logic [15:0] out_cw, out_cw_next;
  logic        out_poll, out_poll_next;
  logic [6:0]  out_seq, out_seq_next;
  logic        out_acked, out_acked_next;
  logic        out_full, out_full_next;
  logic [1:0]  out_timer, out_timer_next;
  logic        out_last, out_last_next;
  logic        load_out;

  logic [6:0]  mask, va, vs, w_eff, end_calc, start, d_raw, d_ack, nxt;
  logic        slot_free, closing, stop, full;

  assign slot_free = !out_valid || m_tready;
  assign mask      = cfg.extended ? 7'h7f : 7'h07;
  assign va        = ack_state & mask;
  assign vs        = send_state & mask;

  // Effective window: zero counts as one, and it stays below the modulus.
  always_comb begin
    w_eff = {1'b0, cfg.window};
    if (w_eff == 7'd0) w_eff = 7'd1;
    if (!cfg.extended && w_eff >= 7'd8) w_eff = 7'd7;
  end

  assign end_calc = (va + w_eff) & mask;
  assign start    = (unacked == 7'd0) ? va : vs;
  assign d_raw    = (q_entry.nr - va) & mask;
  assign d_ack    = (d_raw > unacked) ? unacked : d_raw;
  assign full     = (waiting >= WCW'(QUEUE_DEPTH));
  assign nxt      = (cur + 7'd1) & mask;
  assign closing  = (nxt == end_seq);
  assign stop     = closing || (waiting == WCW'(1)) || (frame_cnt == 6'(MAX_FRAMES - 1));

  // Sequencer: status results, and one frame per cycle on a kick unless stalled.
  always_comb begin
    state_next      = state;
    send_state_next = send_state;
    ack_state_next  = ack_state;
    waiting_next    = waiting;
    unacked_next    = unacked;
    t1_running_next = t1_running;
    cur_next        = cur;
    end_seq_next    = end_seq;
    vr_hold_next    = vr_hold;
    frame_cnt_next  = frame_cnt;
    q_pop           = 1'b0;
    load_out        = 1'b0;
    out_kind_next   = KIND_FRAME;
    out_cw_next     = '0;
    out_poll_next   = 1'b0;
    out_seq_next    = '0;
    out_acked_next  = 1'b0;
    out_full_next   = 1'b0;
    out_timer_next  = TMR_NONE;
    out_last_next   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          unique case (q_entry.op)
            OP_ENQ: begin
              load_out      = 1'b1;
              out_kind_next = KIND_ENQ;
              out_full_next = full;
              out_last_next = 1'b1;
              if (!full) waiting_next = waiting + 1'b1;
            end
            OP_ACK: begin
              load_out      = 1'b1;
              out_kind_next = KIND_ACK;
              out_last_next = 1'b1;
              if (vs == q_entry.nr || va != q_entry.nr) begin
                ack_state_next = (va + d_ack) & mask;
                unacked_next   = unacked - d_ack;
                out_acked_next = 1'b1;
                if (vs == q_entry.nr) begin
                  out_timer_next  = TMR_START_T3;
                  t1_running_next = 1'b0;
                end else begin
                  out_timer_next  = TMR_RESTART_T1;
                  t1_running_next = 1'b1;
                end
              end
            end
            OP_KICK: begin
              if (waiting != '0 && start != end_calc) begin
                state_next     = BK_SEND;
                cur_next       = start;
                end_seq_next   = end_calc;
                vr_hold_next   = q_entry.vr;
                frame_cnt_next = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_SEND: begin
        if (slot_free) begin
          load_out        = 1'b1;
          out_kind_next   = KIND_FRAME;
          out_poll_next   = closing && !cfg.dama;
          out_cw_next     = make_cw(cfg.extended, cur, vr_hold, closing && !cfg.dama);
          out_seq_next    = cur;
          send_state_next = nxt;
          cur_next        = nxt;
          waiting_next    = waiting - 1'b1;
          frame_cnt_next  = frame_cnt + 1'b1;
          if (unacked != 7'd127) unacked_next = unacked + 1'b1;
          if (stop) begin
            out_last_next   = 1'b1;
            out_timer_next  = t1_running ? TMR_NONE : TMR_START_T1;
            t1_running_next = 1'b1;
            state_next      = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    if (load_out) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  // Control state and link variables.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      send_state <= '0;
      ack_state  <= '0;
      waiting    <= '0;
      unacked    <= '0;
      t1_running <= 1'b0;
      frame_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      send_state <= send_state_next;
      ack_state  <= ack_state_next;
      waiting    <= waiting_next;
      unacked    <= unacked_next;
      t1_running <= t1_running_next;
      frame_cnt  <= frame_cnt_next;
      out_valid  <= out_valid_next;
    end
  end

  // Kick working registers and the output register.
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    end_seq <= end_seq_next;
    vr_hold <= vr_hold_next;
    if (load_out) begin
      out_kind  <= out_kind_next;
      out_cw    <= out_cw_next;
      out_poll  <= out_poll_next;
      out_seq   <= out_seq_next;
      out_acked <= out_acked_next;
      out_full  <= out_full_next;
      out_timer <= out_timer_next;
      out_last  <= out_last_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {4'b0000, out_timer, out_full, out_acked, out_seq, out_poll, out_cw};

  // A kick in progress always has a frame left to send.
  assert property (@(posedge clk) disable iff (rst) state == BK_SEND |-> waiting != '0)
    else $error("sending with no frame waiting");

  // A stalled result freezes the kick in progress.
  assert property (@(posedge clk) disable iff (rst)
    (state == BK_SEND && out_valid && !m_tready) |=> $stable(cur) && $stable(waiting))
    else $error("kick advanced while the output was stalled");

  // A kick never runs past its frame limit.
  assert property (@(posedge clk) disable iff (rst)
    state == BK_SEND |-> frame_cnt < 6'(MAX_FRAMES))
    else $error("kick exceeded its frame limit");

  // The waiting count stays within the queue depth.
  assert property (@(posedge clk) disable iff (rst) waiting <= WCW'(QUEUE_DEPTH))
    else $error("waiting count above queue depth");

endmodule

// ===== src/iframe_window_sender.sv =====
// Sender half of a sliding-window link layer with modulo 8 or 128 numbering.
// Commands arrive on the s_ stream: enqueue counts one waiting frame, kick
// sends waiting frames while the window is open, ack applies a received N(R).
// Each result leaves on the m_ stream; tuser gives its kind and tlast marks
// the final result of one command. Enqueue and ack give exactly one result,
// a kick gives zero to 63 frame results, an unknown command gives none.
// An enqueue or ack result passes through the command queue and the output
// register. A kick first sets up in the back, then sends one frame per
// cycle while the receiver does not stall. A four-entry command queue sits
// between the front and the back, so inputs keep flowing while the back
// works on a kick. Configuration writes on cfg_ are always ready and take
// effect at once; they must be made while the block is idle, which the
// block itself does not enforce.
// Reset (rst, synchronous) clears V(S), V(A), both counts, the T1 flag and
// the queue, and loads the registers with modulo 8, window 2, no DAMA slave.
// When the receiver stalls, the output register holds its result, the back
// waits, and the input side stays ready until the command queue is full.
module iframe_window_sender
  import iws_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields, low bit up: ack_number[6:0], receive_seq[6:0], link_connected,
  // peer_busy.
  input  logic [15:0] s_tdata,
  // Fields, low bit up: command[1:0].
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields, low bit up: control_word[15:0], poll, sent_seq[6:0], acked,
  // queue_full, timer_action[1:0], four zero bits.
  output logic [31:0] m_tdata,
  // Fields, low bit up: kind[1:0].
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  cfg_t     cfg;
  logic     q_full;
  logic     q_push;
  q_entry_t push_entry;
  logic     q_pop;
  logic     q_valid;
  q_entry_t pop_entry;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extended <= 1'b0;
      cfg.window   <= 6'd2;
      cfg.dama     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EXTENDED: cfg.extended <= cfg_data[0];
        CFG_WINDOW:   cfg.window   <= cfg_data;
        CFG_DAMA:     cfg.dama     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  iws_front u_front (
    .clk      (clk),
    .rst      (rst),
    .extended (cfg.extended),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  iws_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (push_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (pop_entry)
  );

  iws_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_entry  (pop_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/tb_iframe_window_sender.sv =====
`timescale 1ns / 1ps

module tb_iframe_window_sender;
  import iws_pkg::*;

  // The only register index the block does not decode.
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  // The only command code the block does not decode.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  // Cycles to wait after the last result so that commands without results finish.
  localparam int QUIET_CYCLES = 32;
  localparam int TAIL_CYCLES  = 128;
  // Random commands under each register setting; filling the frame queue
  // already takes most of the command budget.
  localparam int RANDOM_PER_SETTING = 4;

  // One result as it leaves the m_ stream.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] cw;
    logic        poll;
    logic [6:0]  seq;
    logic        acked;
    logic        full;
    logic [1:0]  timer;
    logic [3:0]  pad;
    logic        last;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  // Shadow of the configuration registers.
  logic       reg_extended = 1'b0;
  logic [5:0] reg_window = 6'd2;
  logic       reg_dama = 1'b0;

  // Predicted link state: V(S), V(A), counts and the T1 flag.
  int   win_send_seq = 0;
  int   win_ack_seq = 0;
  int   win_waiting = 0;
  int   win_unacked = 0;
  logic win_t1_running = 1'b0;

  link_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int n_commands = 0;
  int n_checked = 0;
  int n_frames = 0;
  int n_refused = 0;
  int n_saturated = 0;
  int n_biggest_kick = 0;

  iframe_window_sender dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Works out the results of one accepted command and advances the shadow state.
  function automatic void predict_window_step(input logic [1:0] cmd, input logic [15:0] data);
    int mask;
    int modulus;
    int nr;
    int vr;
    int va;
    int vs;
    int w;
    int window_start;
    int window_end;
    int nxt_seq;
    int d;
    int n;
    int plv;
    logic conn;
    logic busy;
    logic closing;
    link_result_t r;
    mask = reg_extended ? 127 : 7;
    modulus = mask + 1;
    nr = int'(data[6:0]) & mask;
    vr = int'(data[13:7]) & mask;
    conn = data[14];
    busy = data[15];
    va = win_ack_seq & mask;
    vs = win_send_seq & mask;
    r = '0;
    case (cmd)
      CMD_ENQUEUE: begin
        r.kind = KIND_ENQ;
        r.last = 1'b1;
        if (win_waiting >= DEFAULT_QUEUE_DEPTH) begin
          r.full = 1'b1;
          n_refused++;
        end else begin
          win_waiting++;
        end
        pending_results.push_back(r);
      end
      CMD_KICK: begin
        if (conn && !busy && win_waiting != 0) begin
          w = int'(reg_window);
          if (w == 0) w = 1;
          if (w >= modulus) w = modulus - 1;
          window_start = (win_unacked == 0) ? va : vs;
          window_end = (va + w) & mask;
          if (window_start != window_end) begin
            vs = window_start;
            n = 0;
            do begin
              nxt_seq = (vs + 1) & mask;
              closing = (nxt_seq == window_end);
              plv = (closing && !reg_dama) ? 1 : 0;
              r = '0;
              r.kind = KIND_FRAME;
              r.poll = plv[0];
              r.seq = 7'(vs);
              if (reg_extended)
                r.cw = 16'((vs << 1) | (plv << 8) | (vr << 9));
              else
                r.cw = 16'((vs << 1) | (plv << 4) | (vr << 5));
              n++;
              vs = nxt_seq;
              win_waiting--;
              if (win_unacked < 127) win_unacked++;
              else n_saturated++;
              // The frame that ends the burst carries the timer action.
              if (closing || win_waiting == 0 || n >= MAX_FRAMES) begin
                r.last = 1'b1;
                if (!win_t1_running) begin
                  r.timer = TMR_START_T1;
                  win_t1_running = 1'b1;
                end
              end
              pending_results.push_back(r);
              n_frames++;
            end while (!closing && win_waiting > 0 && n < MAX_FRAMES);
            win_send_seq = vs;
            if (n > n_biggest_kick) n_biggest_kick = n;
          end
        end
      end
      CMD_ACK: begin
        r.kind = KIND_ACK;
        r.last = 1'b1;
        if (vs == nr || va != nr) begin
          d = (nr - va) & mask;
          if (d > win_unacked) d = win_unacked;
          win_ack_seq = (va + d) & mask;
          win_unacked -= d;
          r.acked = 1'b1;
          if (vs == nr) begin
            r.timer = TMR_START_T3;
            win_t1_running = 1'b0;
          end else begin
            r.timer = TMR_RESTART_T1;
            win_t1_running = 1'b1;
          end
        end
        pending_results.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  // Sends one command transaction, with random idle cycles ahead of it.
  task automatic push_command(input logic [1:0] cmd, input logic [6:0] nr, input logic [6:0] vr,
                              input logic conn, input logic busy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= 16'($urandom);
      s_tuser <= 2'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {busy, conn, vr, nr};
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_commands++;
    predict_window_step(cmd, {busy, conn, vr, nr});
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic wait_link_quiet();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Writes all registers once the block is quiet; bits above bit 0 of the
  // one-bit registers carry noise.
  task automatic set_config(input logic ext, input logic [5:0] win, input logic dama,
                            input bit touch_unused);
    logic [1:0] idx [4];
    logic [5:0] val [4];
    int n;
    wait_link_quiet();
    idx[0] = CFG_EXTENDED;
    val[0] = {5'($urandom), ext};
    idx[1] = CFG_WINDOW;
    val[1] = win;
    idx[2] = CFG_DAMA;
    val[2] = {5'($urandom), dama};
    idx[3] = CFG_UNUSED;
    val[3] = 6'($urandom);
    n = touch_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    reg_extended = ext;
    reg_window = win;
    reg_dama = dama;
  endtask

  // Hand-picked commands: link gating, window closing, every ack outcome,
  // the unknown command, both numbering modes, DAMA poll suppression and a zero window.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_command(CMD_KICK, 7'h00, 7'h00, 1'b1, 1'b0);
    push_command(CMD_ENQUEUE, 7'h7F, 7'h7F, 1'b1, 1'b1);
    push_command(CMD_ENQUEUE, 7'h00, 7'h00, 1'b0, 1'b0);
    push_command(CMD_ENQUEUE, 7'h55, 7'h2A, 1'b0, 1'b1);
    push_command(CMD_KICK, 7'h00, 7'h05, 1'b0, 1'b0);
    push_command(CMD_KICK, 7'h00, 7'h05, 1'b1, 1'b1);
    push_command(CMD_KICK, 7'h00, 7'h7F, 1'b1, 1'b0);
    push_command(CMD_KICK, 7'h00, 7'h03, 1'b1, 1'b0);
    push_command(CMD_ACK, 7'h00, 7'h00, 1'b1, 1'b0);
    push_command(CMD_ACK, 7'h01, 7'h00, 1'b1, 1'b0);
    push_command(CMD_KICK, 7'h00, 7'h06, 1'b1, 1'b0);
    push_command(CMD_ACK, 7'h7B, 7'h00, 1'b0, 1'b1);
    push_command(CMD_UNKNOWN, 7'h7F, 7'h7F, 1'b1, 1'b0);
    push_command(CMD_ENQUEUE, 7'h00, 7'h00, 1'b1, 1'b0);
    push_command(CMD_ENQUEUE, 7'h00, 7'h00, 1'b1, 1'b0);
    // Modulo 128 with the widest window, DAMA slave on.
    set_config(1'b1, 6'd63, 1'b1, 1'b1);
    push_command(CMD_KICK, 7'h00, 7'h7F, 1'b1, 1'b0);
    push_command(CMD_ACK, 7'h05, 7'h00, 1'b1, 1'b0);
    // Window of one under DAMA: the closing frame has no poll.
    set_config(1'b0, 6'd1, 1'b1, 1'b0);
    push_command(CMD_ENQUEUE, 7'h00, 7'h00, 1'b1, 1'b0);
    push_command(CMD_KICK, 7'h00, 7'h02, 1'b1, 1'b0);
    push_command(CMD_ACK, 7'h06, 7'h00, 1'b1, 1'b0);
    // A zero window behaves as a window of one.
    set_config(1'b0, 6'd0, 1'b0, 1'b0);
    push_command(CMD_ENQUEUE, 7'h00, 7'h00, 1'b1, 1'b0);
    push_command(CMD_KICK, 7'h00, 7'h01, 1'b1, 1'b0);
    push_command(CMD_ACK, 7'h07, 7'h00, 1'b1, 1'b0);
  endtask

  // Fills the frame queue to its depth and then offers two more frames.
  task automatic test_queue_full();
    set_config(1'b0, 6'd2, 1'b0, 1'b0);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    while (win_waiting < DEFAULT_QUEUE_DEPTH)
      push_command(CMD_ENQUEUE, 7'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
    repeat (2)
      push_command(CMD_ENQUEUE, 7'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Mode switches between full windows push the unacknowledged count past
  // its ceiling; acks then bring it back to zero.
  task automatic test_counter_saturation();
    repeat (2) begin
      set_config(1'b1, 6'd63, 1'b0, 1'b0);
      push_command(CMD_KICK, 7'($urandom), 7'($urandom), 1'b1, 1'b0);
      set_config(1'b0, 6'd3, 1'b0, 1'b0);
      push_command(CMD_KICK, 7'($urandom), 7'($urandom), 1'b1, 1'b0);
    end
    while (win_unacked > 0)
      push_command(CMD_ACK, 7'((win_ack_seq + 7) & 7), 7'($urandom), 1'b1, 1'b0);
  endtask

  // Random traffic under two register settings per idling mode. Most
  // commands are well formed; acks mostly name a frame inside the window.
  task automatic test_random_traffic(input int phase, input int idle_pct, input int stall_pct,
                                     input bit pause_midway);
    int roll;
    int mask;
    int k;
    logic [1:0] cmd;
    logic [6:0] nr;
    logic conn;
    logic busy;
    for (int s = 0; s < 2; s++) begin
      case (phase * 2 + s)
        0: set_config(1'b0, 6'd7, 1'b0, 1'b0);
        1: set_config(1'b1, 6'd63, 1'b0, 1'b0);
        2: set_config(1'b0, 6'd1, 1'b1, 1'b0);
        3: set_config(1'b1, 6'd5, 1'b1, 1'b0);
        4: set_config(1'b1, 6'd1, 1'b0, 1'b0);
        5: set_config(1'b0, 6'd63, 1'b0, 1'b1);
        6: set_config(1'b1, 6'd0, 1'b0, 1'b0);
        default: set_config(1'b0, 6'd3, 1'b1, 1'b0);
      endcase
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
        if (pause_midway && i == RANDOM_PER_SETTING / 2) wait_link_quiet();
        mask = reg_extended ? 127 : 7;
        roll = $urandom_range(0, 99);
        nr = 7'($urandom);
        conn = 1'b1;
        busy = 1'b0;
        if (roll < 35) begin
          cmd = CMD_ENQUEUE;
          conn = 1'($urandom);
          busy = 1'($urandom);
        end else if (roll < 65) begin
          cmd = CMD_KICK;
          if ($urandom_range(0, 99) < 15) begin
            conn = 1'($urandom);
            busy = 1'($urandom);
          end
        end else if (roll < 95) begin
          cmd = CMD_ACK;
          conn = 1'($urandom);
          busy = 1'($urandom);
          if ($urandom_range(0, 99) < 75) begin
            k = $urandom_range(0, win_unacked);
            nr = 7'((win_ack_seq + k) & mask);
            if (!reg_extended) nr[6:3] = 4'($urandom);
          end
        end else begin
          cmd = CMD_UNKNOWN;
        end
        push_command(cmd, nr, 7'($urandom), conn, busy);
      end
    end
  endtask

  // Receiver: ready is redrawn every cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    link_result_t got;
    link_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind  = m_tuser;
      got.cw    = m_tdata[15:0];
      got.poll  = m_tdata[16];
      got.seq   = m_tdata[23:17];
      got.acked = m_tdata[24];
      got.full  = m_tdata[25];
      got.timer = m_tdata[27:26];
      got.pad   = m_tdata[31:28];
      got.last  = m_tlast;
      n_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result at %0t: kind=%0d data=%h last=%0d",
                   $realtime, m_tuser, m_tdata, m_tlast);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.cw !== want.cw || got.poll !== want.poll ||
            got.seq !== want.seq || got.acked !== want.acked || got.full !== want.full ||
            got.timer !== want.timer || got.pad !== want.pad || got.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch at %0t: expected kind=%0d cw=%h poll=%0d seq=%0d acked=%0d",
                     $realtime, want.kind, want.cw, want.poll, want.seq, want.acked);
            $display("  full=%0d timer=%0d pad=%h last=%0d; got kind=%0d cw=%h poll=%0d",
                     want.full, want.timer, want.pad, want.last, got.kind, got.cw, got.poll);
            $display("  seq=%0d acked=%0d full=%0d timer=%0d pad=%h last=%0d",
                     got.seq, got.acked, got.full, got.timer, got.pad, got.last);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin : run_tests
    int guard;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_queue_full();
    test_counter_saturation();
    test_random_traffic(0, 0, 0, 1'b0);
    test_random_traffic(1, 70, 0, 1'b1);
    test_random_traffic(2, 0, 70, 1'b0);
    test_random_traffic(3, 20, 20, 1'b0);

    // Let the last results drain, with a bound of its own.
    s_tvalid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $display("%0d predicted results never arrived", pending_results.size());
      errors += pending_results.size();
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d commands and %0d checked results, %0d of them sent frames",
             n_commands, n_checked, n_frames);
    $display("Refused enqueues: %0d, frames past the unacked ceiling: %0d, longest burst: %0d",
             n_refused, n_saturated, n_biggest_kick);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still predicted", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
src/iws_pkg.sv
src/iws_front.sv
src/iws_fifo.sv
src/iws_back.sv
src/iframe_window_sender.sv
tb/tb_iframe_window_sender.sv
